// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, ck, rn, ant, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, ck, rn, ant, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/sfd_pkg.sv -----
`timescale 1ns / 1ps

package sfd_pkg;

    // Default largest payload the counter is sized for.
    localparam int MAX_PAYLOAD_DEF = 1024;

    localparam int LEN_W = 11;
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd256;

    localparam logic [7:0] SYNC_FIRST  = 8'h42;
    localparam logic [7:0] SYNC_SECOND = 8'h46;

    // Parser phase codes.
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_CKLO  = 3'd3;
    localparam logic [2:0] PH_CKHI  = 3'd4;

    // Event kinds carried on the output tuser.
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PAYLOAD = 2'd1;
    localparam logic [1:0] EV_GOOD    = 2'd2;
    localparam logic [1:0] EV_BAD     = 2'd3;

    localparam int IDX_W   = 10;
    localparam int TDATA_W = 24;

    typedef struct packed {
        logic [1:0]       event_kind;
        logic [7:0]       payload_byte;
        logic [IDX_W-1:0] byte_index;
    } result_t;

endpackage

// ----- rtl/sfd_parser.sv -----
`timescale 1ns / 1ps

module sfd_parser #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [sfd_pkg::LEN_W-1:0] cfg_length,
    input  logic                    in_accept,
    input  logic [7:0]              rx_byte,
    output sfd_pkg::result_t        result
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int LW = (CW > sfd_pkg::LEN_W) ? CW : sfd_pkg::LEN_W;

    logic [sfd_pkg::LEN_W-1:0] length_reg;
    logic [2:0]                phase_reg, phase_next;
    logic [CW-1:0]             count_reg, count_next, count_inc;
    logic [7:0]                sum_a_reg, sum_a_next, sum_a_add;
    logic [7:0]                sum_b_reg, sum_b_next;
    logic [7:0]                check_low_reg, check_low_next;
    logic [LW-1:0]             len_ext, max_ext, eff_len;
    logic [CW+sfd_pkg::IDX_W-1:0] idx_wide;

    // Effective length: zero acts as one, oversize clamps to the maximum.
    assign len_ext = LW'(length_reg);
    assign max_ext = LW'(MAX_PAYLOAD);

    always_comb
    begin
        if (len_ext == '0)
        begin
            eff_len = LW'(1);
        end
        else if (len_ext > max_ext)
        begin
            eff_len = max_ext;
        end
        else
        begin
            eff_len = len_ext;
        end
    end

    assign count_inc = count_reg + CW'(1);
    assign sum_a_add = sum_a_reg + rx_byte;
    assign idx_wide  = {{sfd_pkg::IDX_W{1'b0}}, count_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        check_low_next = check_low_reg;
        result         = '0;
        unique case (phase_reg)
            sfd_pkg::PH_SYNC2:
            begin
                if (rx_byte == sfd_pkg::SYNC_SECOND)
                begin
                    phase_next = sfd_pkg::PH_DATA;
                    count_next = '0;
                    sum_a_next = '0;
                    sum_b_next = '0;
                end
                else if (rx_byte != sfd_pkg::SYNC_FIRST)
                begin
                    phase_next = sfd_pkg::PH_HUNT;
                end
            end
            sfd_pkg::PH_DATA:
            begin
                result.event_kind   = sfd_pkg::EV_PAYLOAD;
                result.payload_byte = rx_byte;
                result.byte_index   = idx_wide[sfd_pkg::IDX_W-1:0];
                sum_a_next          = sum_a_add;
                sum_b_next          = sum_b_reg + sum_a_add;
                count_next          = count_inc;
                if (LW'(count_inc) >= eff_len)
                begin
                    phase_next = sfd_pkg::PH_CKLO;
                end
            end
            sfd_pkg::PH_CKLO:
            begin
                check_low_next = rx_byte;
                phase_next     = sfd_pkg::PH_CKHI;
            end
            sfd_pkg::PH_CKHI:
            begin
                if (sum_a_reg == check_low_reg && sum_b_reg == rx_byte)
                begin
                    result.event_kind = sfd_pkg::EV_GOOD;
                end
                else
                begin
                    result.event_kind = sfd_pkg::EV_BAD;
                end
                phase_next = sfd_pkg::PH_HUNT;
            end
            default:
            begin
                // Hunting, and any code that should never occur.
                phase_next = (rx_byte == sfd_pkg::SYNC_FIRST) ? sfd_pkg::PH_SYNC2
                                                              : sfd_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= sfd_pkg::LEN_RESET;
            phase_reg     <= sfd_pkg::PH_HUNT;
            count_reg     <= '0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            check_low_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                length_reg <= cfg_length;
            end
            if (in_accept)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                sum_a_reg     <= sum_a_next;
                sum_b_reg     <= sum_b_next;
                check_low_reg <= check_low_next;
            end
        end
    end

endmodule

// ----- rtl/sfd_skid.sv -----
`timescale 1ns / 1ps

module sfd_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfd_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sfd_pkg::result_t out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    sfd_pkg::result_t out_data_reg, out_data_next;
    sfd_pkg::result_t skid_data_reg, skid_data_next;
    logic             take;

    assign in_ready  = !skid_valid_reg;
    assign take      = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = in_data;
                out_valid_next = take;
            end
        end
        else if (take)
        begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- rtl/sync_fletcher_packet_deframer_unit.sv -----
`timescale 1ns / 1ps
// A result request is registered when its byte is taken, in the skid entry if the output stalls.
// Throughput: one byte per cycle while s_tready is high, updating phase and the two 8-bit sums.
// Stall: the skid register takes one more byte while the output stalls, then s_tready drops.
// Reset (rst_n low, asynchronous) returns to hunting, clears sums and count, length to 256.

module sync_fletcher_packet_deframer_unit #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Receive stream; s_tdata: rx_byte [7:0].
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    // Event stream; m_tdata: payload_byte [7:0], byte_index [17:8], zeros [23:18].
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sfd_pkg::TDATA_W-1:0] m_tdata,
    // m_tuser: event_kind [1:0].
    output logic [1:0]                  m_tuser,
    // Payload length write; cfg_data: payload_length [10:0].
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sfd_pkg::LEN_W-1:0]   cfg_data
);

    logic             in_accept;
    sfd_pkg::result_t parse_result;
    sfd_pkg::result_t out_result;

    // The length register can always be written; the host must do so only while idle, unenforced here.
    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    // Phase machine and Fletcher sums. Every accepted byte yields exactly one result
    // request, which is "nothing" for header and low checksum bytes.
    sfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_length (cfg_data),
        .in_accept  (in_accept),
        .rx_byte    (s_tdata),
        .result     (parse_result)
    );

    // Output register with a skid entry behind it, so that s_tready only drops once
    // both are occupied and the downstream side is stalling.
    sfd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parse_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tuser = out_result.event_kind;
    assign m_tdata = {{(sfd_pkg::TDATA_W - sfd_pkg::IDX_W - 8){1'b0}},
                      out_result.byte_index, out_result.payload_byte};

endmodule

// ----- rtl/sfd_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [sfd_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                  m_tuser
);

    // A stalled result request keeps its value.
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

    // With the output register empty the skid entry is empty too, so input is taken.
    `ASSERT_IMPLIES(a_empty_ready, clk, rst_n, !m_tvalid, s_tready)

    // Only payload events carry data and an index.
    `ASSERT_IMPLIES(a_nodata_zero, clk, rst_n, m_tvalid && m_tuser != sfd_pkg::EV_PAYLOAD, m_tdata == '0)

    // A byte offered while the output stage is empty is taken at once.
    `ASSERT_IMPLIES(a_empty_take, clk, rst_n, s_tvalid && !m_tvalid, s_tready)

endmodule

bind sync_fletcher_packet_deframer_unit sfd_checker u_sfd_checker (.*);
